### rtl/fcb_pkg.sv
package fcb_pkg;

  localparam int FCB_LEN   = 12;
  localparam int NAME_LAST = 8;
  localparam int EXT_FIRST = 9;
  localparam int EXT_LAST  = 11;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic [3:0] fcb_idx_t;
  typedef logic [7:0] byte_t;

  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_STAR  = 8'h2A;
  localparam byte_t CH_DOT   = 8'h2E;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_QMARK = 8'h3F;
  localparam byte_t CH_UC_A  = 8'h41;
  localparam byte_t CH_UC_P  = 8'h50;
  localparam byte_t CH_LC_A  = 8'h61;
  localparam byte_t CH_LC_P  = 8'h70;
  localparam byte_t CH_LC_Z  = 8'h7A;
  localparam byte_t CASE_GAP = 8'h20;

  localparam fcb_idx_t IDX_DRIVE = 4'd0;
  localparam fcb_idx_t IDX_LAST  = 4'(EXT_LAST);

  // One queued command: up to two single-byte writes, a '?' fill mask,
  // and an optional emit that snapshots the block after the writes.
  typedef struct packed {
    logic               emit;
    logic [FCB_LEN-1:0] fill;
    logic               wr0_en;
    fcb_idx_t           wr0_idx;
    byte_t              wr0_data;
    logic               wr1_en;
    fcb_idx_t           wr1_idx;
    byte_t              wr1_data;
  } fcb_op_t;

  function automatic byte_t upcase(byte_t c);
    return (c >= CH_LC_A && c <= CH_LC_Z) ? byte_t'(c - CASE_GAP) : c;
  endfunction

endpackage

### rtl/fcb_ifs.sv
interface fcb_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface fcb_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [3:0] fcb_index;
  logic [7:0] fcb_byte;
  logic       last_byte;

  modport source (output valid, output fcb_index, output fcb_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input fcb_index, input fcb_byte, input last_byte,
                  output ready);
endinterface

### rtl/fcb_front.sv
module fcb_front (
  input  logic           clk,
  input  logic           rst_n,
  fcb_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output fcb_pkg::fcb_op_t q_op
);

  typedef enum logic [4:0] {
    PH_FIRST  = 5'b00001,
    PH_SECOND = 5'b00010,
    PH_NAME   = 5'b00100,
    PH_EXT    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t                      ph;
    fcb_pkg::fcb_idx_t           pos;
    logic                        wr;
    fcb_pkg::fcb_idx_t           idx;
    fcb_pkg::byte_t              data;
    logic [fcb_pkg::FCB_LEN-1:0] fill;
  } body_t;

  function automatic logic [fcb_pkg::FCB_LEN-1:0] span(fcb_pkg::fcb_idx_t lo,
                                                       fcb_pkg::fcb_idx_t hi);
    logic [fcb_pkg::FCB_LEN-1:0] m;
    for (int i = 0; i < fcb_pkg::FCB_LEN; i++) begin
      m[i] = (4'(i) >= lo) && (4'(i) <= hi);
    end
    return m;
  endfunction

  // One body character in the name, extension or done phase.
  function automatic body_t feed_body(phase_t ph, fcb_pkg::fcb_idx_t pos,
                                      fcb_pkg::byte_t c);
    body_t r;
    r.ph   = ph;
    r.pos  = pos;
    r.wr   = 1'b0;
    r.idx  = pos;
    r.data = fcb_pkg::upcase(c);
    r.fill = '0;
    case (ph)
      PH_NAME: begin
        if (c == fcb_pkg::CH_DOT) begin
          r.ph  = PH_EXT;
          r.pos = 4'(fcb_pkg::EXT_FIRST);
        end else if (c == fcb_pkg::CH_SPACE) begin
          r.ph = PH_DONE;
        end else if (pos >= 4'd1 && pos <= 4'(fcb_pkg::NAME_LAST)) begin
          if (c == fcb_pkg::CH_STAR) begin
            r.fill = span(pos, 4'(fcb_pkg::NAME_LAST));
            r.pos  = 4'(fcb_pkg::EXT_FIRST);
          end else begin
            r.wr  = 1'b1;
            r.pos = pos + 4'd1;
          end
        end
      end
      PH_EXT: begin
        if (c == fcb_pkg::CH_SPACE || pos < 4'(fcb_pkg::EXT_FIRST) ||
            pos > 4'(fcb_pkg::EXT_LAST)) begin
          r.ph = PH_DONE;
        end else if (c == fcb_pkg::CH_STAR) begin
          r.fill = span(pos, 4'(fcb_pkg::EXT_LAST));
          r.pos  = 4'(fcb_pkg::EXT_LAST + 1);
          r.ph   = PH_DONE;
        end else begin
          r.wr  = 1'b1;
          r.pos = pos + 4'd1;
          if (pos == 4'(fcb_pkg::EXT_LAST)) begin
            r.ph = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  phase_t            ph_r, ph_nxt;
  fcb_pkg::byte_t    held_r, held_nxt;
  fcb_pkg::fcb_idx_t pos_r, pos_nxt;
  fcb_pkg::byte_t    c;
  logic              xfer;
  body_t             b0, b1;
  phase_t            b1_ph;
  fcb_pkg::fcb_idx_t b1_pos;
  fcb_pkg::fcb_op_t  op;

  assign c           = in_ch.character;
  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && !q_full;

  // unless a colon follows, the held character is replayed as the first name character
  assign b0     = feed_body(PH_NAME, 4'd1, held_r);
  assign b1_ph  = (ph_r == PH_SECOND) ? b0.ph  : ph_r;
  assign b1_pos = (ph_r == PH_SECOND) ? b0.pos : pos_r;
  assign b1     = feed_body(b1_ph, b1_pos, c);

  always_comb begin
    op       = '0;
    ph_nxt   = ph_r;
    held_nxt = held_r;
    pos_nxt  = pos_r;
    case (ph_r)
      PH_FIRST: begin
        if (c != fcb_pkg::CH_NUL) begin
          held_nxt = c;
          ph_nxt   = PH_SECOND;
        end else begin
          op.emit = 1'b1;
        end
      end
      PH_SECOND: begin
        if (c == fcb_pkg::CH_COLON) begin
          ph_nxt      = PH_NAME;
          pos_nxt     = 4'd1;
          op.wr0_idx  = fcb_pkg::IDX_DRIVE;
          if (held_r >= fcb_pkg::CH_LC_A && held_r <= fcb_pkg::CH_LC_P) begin
            op.wr0_en   = 1'b1;
            op.wr0_data = held_r - fcb_pkg::CH_LC_A + 8'd1;
          end else if (held_r >= fcb_pkg::CH_UC_A && held_r <= fcb_pkg::CH_UC_P) begin
            op.wr0_en   = 1'b1;
            op.wr0_data = held_r - fcb_pkg::CH_UC_A + 8'd1;
          end
        end else begin
          op.wr0_en   = b0.wr;
          op.wr0_idx  = b0.idx;
          op.wr0_data = b0.data;
          op.fill     = b0.fill;
          ph_nxt      = b0.ph;
          pos_nxt     = b0.pos;
          if (c != fcb_pkg::CH_NUL) begin
            op.wr1_en   = b1.wr;
            op.wr1_idx  = b1.idx;
            op.wr1_data = b1.data;
            op.fill     = b0.fill | b1.fill;
            ph_nxt      = b1.ph;
            pos_nxt     = b1.pos;
          end else begin
            op.emit = 1'b1;
          end
        end
      end
      default: begin
        if (c != fcb_pkg::CH_NUL) begin
          op.wr1_en   = b1.wr;
          op.wr1_idx  = b1.idx;
          op.wr1_data = b1.data;
          op.fill     = b1.fill;
          ph_nxt      = b1.ph;
          pos_nxt     = b1.pos;
        end else begin
          op.emit = 1'b1;
        end
      end
    endcase
    if (op.emit) begin
      ph_nxt   = PH_FIRST;
      held_nxt = fcb_pkg::CH_NUL;
      pos_nxt  = 4'd1;
    end
  end

  assign q_op   = op;
  assign q_push = xfer && (op.emit || op.wr0_en || op.wr1_en || (op.fill != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_FIRST;
      held_r <= fcb_pkg::CH_NUL;
      pos_r  <= 4'd1;
    end else if (xfer) begin
      ph_r   <= ph_nxt;
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

### rtl/fcb_queue.sv
module fcb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fcb_pkg::fcb_op_t din,
  output logic             full,
  input  logic             pop,
  output fcb_pkg::fcb_op_t dout,
  output logic             empty
);

  fcb_pkg::fcb_op_t              mem_r [fcb_pkg::QDEPTH];
  logic [fcb_pkg::QAW-1:0]       wp_r, rp_r;
  logic [fcb_pkg::QAW:0]         cnt_r;

  assign full  = (cnt_r == (fcb_pkg::QAW+1)'(fcb_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/fcb_back.sv
module fcb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  fcb_pkg::fcb_op_t q_op,
  input  logic             q_empty,
  output logic             q_pop,
  fcb_out_if.source        out_ch
);

  fcb_pkg::byte_t    store_r [fcb_pkg::FCB_LEN];
  fcb_pkg::byte_t    obuf_r  [fcb_pkg::FCB_LEN];
  fcb_pkg::byte_t    merged  [fcb_pkg::FCB_LEN];
  fcb_pkg::fcb_idx_t cnt_r;
  logic              busy_r;
  logic              out_xfer, out_last;

  assign out_xfer = busy_r && out_ch.ready;
  assign out_last = (cnt_r == fcb_pkg::IDX_LAST);

  // an emit may load the buffer in the cycle its last byte goes out
  assign q_pop = !q_empty && (!q_op.emit || !busy_r || (out_xfer && out_last));

  always_comb begin
    for (int i = 0; i < fcb_pkg::FCB_LEN; i++) begin
      merged[i] = store_r[i];
      if (q_op.fill[i]) merged[i] = fcb_pkg::CH_QMARK;
      if (q_op.wr0_en && q_op.wr0_idx == 4'(i)) merged[i] = q_op.wr0_data;
      if (q_op.wr1_en && q_op.wr1_idx == 4'(i)) merged[i] = q_op.wr1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fcb_pkg::FCB_LEN; i++) begin
        store_r[i] <= (i == 0) ? fcb_pkg::CH_NUL : fcb_pkg::CH_SPACE;
      end
    end else if (q_pop) begin
      for (int i = 0; i < fcb_pkg::FCB_LEN; i++) begin
        if (q_op.emit) begin
          store_r[i] <= (i == 0) ? fcb_pkg::CH_NUL : fcb_pkg::CH_SPACE;
        end else begin
          store_r[i] <= merged[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op.emit) begin
      for (int i = 0; i < fcb_pkg::FCB_LEN; i++) begin
        obuf_r[i] <= merged[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (q_pop && q_op.emit) begin
        busy_r <= 1'b1;
        cnt_r  <= fcb_pkg::IDX_DRIVE;
      end else if (out_xfer) begin
        if (out_last) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  assign out_ch.valid     = busy_r;
  assign out_ch.fcb_index = cnt_r;
  assign out_ch.fcb_byte  = obuf_r[cnt_r];
  assign out_ch.last_byte = out_last;

endmodule

### rtl/fcb_filename_parser.sv
// Throughput: one character accepted per cycle; the end marker yields 12 bytes, one per
//   cycle while out_ch is ready, from a 12-byte output buffer while the next string is
//   parsed. Byte 0 valid once the marker's command passes the queue to a free buffer.
// Input stalls only when the 4-entry command queue is full behind a draining buffer.
// Reset (rst_n low, synchronous): parser awaits a first character, block holds
//   drive 0 and eleven spaces, queue and output buffer empty.
module fcb_filename_parser (
  input  logic      clk,
  input  logic      rst_n,
  fcb_in_if.sink    in_ch,
  fcb_out_if.source out_ch
);

  fcb_pkg::fcb_op_t push_op, pop_op;
  logic             push, pop, full, empty;

  fcb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_op   (push_op)
  );

  fcb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_op),
    .full  (full),
    .pop   (pop),
    .dout  (pop_op),
    .empty (empty)
  );

  fcb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_op    (pop_op),
    .q_empty (empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/fcb_checker.sv
module fcb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_fcb_index,
  input logic [7:0] out_fcb_byte,
  input logic       out_last_byte
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fcb_index) &&
                                $stable(out_fcb_byte))
    else $error("result changed while stalled");

  // bytes of one block go out in index order without gaps
  a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=>
      out_valid && (out_fcb_index == $past(out_fcb_index) + 4'd1))
    else $error("block index sequence broken");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_fcb_index == 4'd11)
    else $error("last flag off the final byte");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fcb_index == 4'd0 |-> out_fcb_byte <= 8'd16)
    else $error("drive number out of range");

endmodule

bind fcb_filename_parser fcb_checker u_fcb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_fcb_index (out_ch.fcb_index),
  .out_fcb_byte  (out_ch.fcb_byte),
  .out_last_byte (out_ch.last_byte)
);

### sim/fcb_filename_parser_test.sv
`timescale 1ns / 100ps

module fcb_filename_parser_test;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_CHARS = 80;
  localparam logic [8*(fcb_pkg::FCB_LEN-1)-1:0] ALL_BLANK = "           ";
  localparam logic [8*(fcb_pkg::FCB_LEN-1)-1:0] ALL_QMARK = "???????????";
  localparam logic [8*(fcb_pkg::FCB_LEN-1)-1:0] JUST_A    = "A          ";

  typedef enum logic [2:0] {AWAIT_FIRST, AWAIT_SECOND, IN_NAME, IN_EXT, PARSE_DONE} parse_state_t;

  typedef struct {
    fcb_pkg::fcb_idx_t idx;
    fcb_pkg::byte_t    val;
    logic              last;
  } fcb_entry_t;

  // Directed script; body holds slots 1..11, first character in the top byte.
  typedef struct packed {
    fcb_pkg::byte_t                       ch;
    logic                                 typed;
    fcb_pkg::byte_t                       drive;
    logic [8*(fcb_pkg::FCB_LEN-1)-1:0]    body;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT[SCRIPT_LEN] = '{
    '{fcb_pkg::CH_NUL,   1'b1, 8'd0,  ALL_BLANK},
    '{fcb_pkg::CH_UC_P,  1'b0, 8'd0,  ALL_BLANK}, '{fcb_pkg::CH_COLON, 1'b0, 8'd0, ALL_BLANK},
    '{fcb_pkg::CH_STAR,  1'b0, 8'd0,  ALL_BLANK}, '{fcb_pkg::CH_DOT,   1'b0, 8'd0, ALL_BLANK},
    '{fcb_pkg::CH_STAR,  1'b0, 8'd0,  ALL_BLANK},
    '{fcb_pkg::CH_NUL,   1'b1, 8'd16, ALL_QMARK},
    '{fcb_pkg::CH_LC_A,  1'b0, 8'd0,  ALL_BLANK},
    '{fcb_pkg::CH_NUL,   1'b1, 8'd0,  JUST_A},
    '{8'h71,             1'b0, 8'd0,  ALL_BLANK}, '{fcb_pkg::CH_COLON, 1'b0, 8'd0, ALL_BLANK},
    '{8'hFF,             1'b0, 8'd0,  ALL_BLANK}, '{8'h80,             1'b0, 8'd0, ALL_BLANK},
    '{8'h63,             1'b0, 8'd0,  ALL_BLANK}, '{8'h64,             1'b0, 8'd0, ALL_BLANK},
    '{8'h65,             1'b0, 8'd0,  ALL_BLANK}, '{8'h66,             1'b0, 8'd0, ALL_BLANK},
    '{8'h67,             1'b0, 8'd0,  ALL_BLANK}, '{8'h68,             1'b0, 8'd0, ALL_BLANK},
    '{8'h69,             1'b0, 8'd0,  ALL_BLANK},
    '{fcb_pkg::CH_DOT,   1'b0, 8'd0,  ALL_BLANK}, '{fcb_pkg::CH_DOT,   1'b0, 8'd0, ALL_BLANK},
    '{8'h62,             1'b0, 8'd0,  ALL_BLANK}, '{fcb_pkg::CH_SPACE, 1'b0, 8'd0, ALL_BLANK},
    '{fcb_pkg::CH_NUL,   1'b0, 8'd0,  ALL_BLANK}
  };

  logic clk = 1'b0;
  logic rst_n;

  fcb_in_if  in_ch (.clk(clk));
  fcb_out_if out_ch (.clk(clk));

  fcb_filename_parser i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Parser shadow state
  parse_state_t      prs_state;
  fcb_pkg::byte_t    held_char;
  fcb_pkg::fcb_idx_t slot;
  fcb_pkg::byte_t    image[fcb_pkg::FCB_LEN];
  fcb_pkg::byte_t    emitted_img[fcb_pkg::FCB_LEN];

  fcb_entry_t        pending_bytes[$];
  fcb_entry_t        want;
  bit                override_on;
  fcb_pkg::byte_t    override_img[fcb_pkg::FCB_LEN];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches = 0;
  int bytes_checked = 0;
  int strings_sent;
  int chars_sent;
  int quiet_cycles = 0;

  function automatic void clear_image();
    foreach (image[k]) image[k] = fcb_pkg::CH_SPACE;
    image[fcb_pkg::IDX_DRIVE] = fcb_pkg::CH_NUL;
    prs_state = AWAIT_FIRST;
    held_char = fcb_pkg::CH_NUL;
    slot = 4'd1;
  endfunction

  function automatic fcb_pkg::byte_t fold_case(fcb_pkg::byte_t c);
    if (c >= fcb_pkg::CH_LC_A && c <= fcb_pkg::CH_LC_Z) return c - fcb_pkg::CASE_GAP;
    return c;
  endfunction

  function automatic void take_body(fcb_pkg::byte_t c);
    if (prs_state == IN_NAME) begin
      if (c == fcb_pkg::CH_DOT) begin
        prs_state = IN_EXT;
        slot = fcb_pkg::fcb_idx_t'(fcb_pkg::EXT_FIRST);
      end else if (c == fcb_pkg::CH_SPACE) begin
        prs_state = PARSE_DONE;
      end else if (slot >= 1 && slot <= fcb_pkg::NAME_LAST) begin
        if (c == fcb_pkg::CH_STAR) begin
          while (slot <= fcb_pkg::NAME_LAST) begin
            image[slot] = fcb_pkg::CH_QMARK;
            slot++;
          end
        end else begin
          image[slot] = fold_case(c);
          slot++;
        end
      end
    end else if (prs_state == IN_EXT) begin
      if (c == fcb_pkg::CH_SPACE || slot < fcb_pkg::EXT_FIRST || slot > fcb_pkg::EXT_LAST) begin
        prs_state = PARSE_DONE;
      end else if (c == fcb_pkg::CH_STAR) begin
        while (slot <= fcb_pkg::EXT_LAST) begin
          image[slot] = fcb_pkg::CH_QMARK;
          slot++;
        end
        prs_state = PARSE_DONE;
      end else begin
        image[slot] = fold_case(c);
        slot++;
        if (slot > fcb_pkg::EXT_LAST) prs_state = PARSE_DONE;
      end
    end
  endfunction

  // Returns 1 when the character closes the string; the block is then in emitted_img.
  function automatic bit advance_parser(fcb_pkg::byte_t c);
    case (prs_state)
      AWAIT_FIRST: begin
        if (c != fcb_pkg::CH_NUL) begin
          held_char = c;
          prs_state = AWAIT_SECOND;
          return 1'b0;
        end
      end
      AWAIT_SECOND: begin
        if (c == fcb_pkg::CH_COLON) begin
          if (held_char >= fcb_pkg::CH_LC_A && held_char <= fcb_pkg::CH_LC_P)
            image[fcb_pkg::IDX_DRIVE] = held_char - fcb_pkg::CH_LC_A + 8'd1;
          else if (held_char >= fcb_pkg::CH_UC_A && held_char <= fcb_pkg::CH_UC_P)
            image[fcb_pkg::IDX_DRIVE] = held_char - fcb_pkg::CH_UC_A + 8'd1;
          prs_state = IN_NAME;
          slot = 4'd1;
          return 1'b0;
        end
        prs_state = IN_NAME;
        slot = 4'd1;
        take_body(held_char);
        if (c != fcb_pkg::CH_NUL) begin
          take_body(c);
          return 1'b0;
        end
      end
      default: begin
        if (c != fcb_pkg::CH_NUL) begin
          take_body(c);
          return 1'b0;
        end
      end
    endcase
    emitted_img = image;
    clear_image();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_char(input fcb_pkg::byte_t c, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (counted) chars_sent++;
    if (advance_parser(c)) begin
      strings_sent++;
      for (int k = 0; k < fcb_pkg::FCB_LEN; k++)
        pending_bytes.push_back(fcb_entry_t'{fcb_pkg::fcb_idx_t'(k),
                                             override_on ? override_img[k] : emitted_img[k],
                                             k == fcb_pkg::EXT_LAST});
    end
  endtask

  // Hold off the sender until every block has drained.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic fcb_pkg::byte_t pick_text_char();
    int r;
    r = $urandom_range(19);
    if (r == 0) return fcb_pkg::CH_STAR;
    if (r == 1) return fcb_pkg::byte_t'($urandom_range(128, 255));
    if (r <= 3) return fcb_pkg::byte_t'(8'h30 + $urandom_range(9));
    if (r <= 11) return fcb_pkg::byte_t'(fcb_pkg::CH_LC_A + $urandom_range(25));
    return fcb_pkg::byte_t'(fcb_pkg::CH_UC_A + $urandom_range(25));
  endfunction

  function automatic fcb_pkg::byte_t pick_drive_letter();
    if ($urandom_range(7) == 0) return fcb_pkg::byte_t'(8'h30 + $urandom_range(9));
    return fcb_pkg::byte_t'(($urandom_range(1) ? fcb_pkg::CH_UC_A : fcb_pkg::CH_LC_A) +
                            $urandom_range(25));
  endfunction

  task automatic send_random_string();
    int kind;
    int n;
    kind = $urandom_range(9);
    if (kind == 9) begin
      // noise: any nonzero bytes
      n = $urandom_range(1, 12);
      repeat (n) send_char(fcb_pkg::byte_t'($urandom_range(1, 255)), 1'b1);
    end else if (kind == 8) begin
      // cut short: a lone character or a bare prefix
      send_char(pick_text_char(), 1'b1);
      if ($urandom_range(1)) send_char(fcb_pkg::CH_COLON, 1'b1);
    end else begin
      if ($urandom_range(1)) begin
        send_char(pick_drive_letter(), 1'b1);
        send_char(fcb_pkg::CH_COLON, 1'b1);
      end
      n = $urandom_range(0, 10);
      repeat (n) send_char(pick_text_char(), 1'b1);
      if ($urandom_range(9) < 7) begin
        send_char(fcb_pkg::CH_DOT, 1'b1);
        n = $urandom_range(0, 4);
        repeat (n) send_char(($urandom_range(7) == 0) ? fcb_pkg::CH_DOT : pick_text_char(),
                             1'b1);
      end
      if ($urandom_range(3) == 0) begin
        send_char(fcb_pkg::CH_SPACE, 1'b1);
        n = $urandom_range(0, 3);
        repeat (n) send_char(fcb_pkg::byte_t'($urandom_range(1, 255)), 1'b0);
      end
    end
    send_char(fcb_pkg::CH_NUL, 1'b1);
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte: index %0d value %02h last %0b",
                                out_ch.fcb_index, out_ch.fcb_byte, out_ch.last_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.fcb_index !== want.idx)
          flag_mismatch($sformatf("fcb_index %0d, want %0d", out_ch.fcb_index, want.idx));
        if (out_ch.fcb_byte !== want.val)
          flag_mismatch($sformatf("fcb_byte %02h at index %0d, want %02h",
                                  out_ch.fcb_byte, want.idx, want.val));
        if (out_ch.last_byte !== want.last)
          flag_mismatch($sformatf("last_byte %0b at index %0d, want %0b",
                                  out_ch.last_byte, want.idx, want.last));
      end
    end
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d bytes outstanding",
                 QUIET_LIMIT, pending_bytes.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.character = fcb_pkg::CH_NUL;
    send_idle_pct   = 16;
    recv_stall_pct  = 58;
    strings_sent    = 0;
    chars_sent      = 0;
    override_on     = 1'b0;
    clear_image();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[r]) begin
      override_on = SCRIPT[r].typed;
      override_img[fcb_pkg::IDX_DRIVE] = SCRIPT[r].drive;
      for (int k = 1; k < fcb_pkg::FCB_LEN; k++)
        override_img[k] = SCRIPT[r].body[8*(fcb_pkg::FCB_LEN-k)-1 -: 8];
      send_char(SCRIPT[r].ch, 1'b1);
      override_on = 1'b0;
    end
    drain_results();

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= 2 * RANDOM_CHARS / 3 && send_idle_pct != 0) begin
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (chars_sent >= RANDOM_CHARS / 3 && send_idle_pct == 16) begin
        drain_results();
        send_idle_pct  = 58;
        recv_stall_pct = 16;
      end
      send_random_string();
    end

    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d strings (directed and random) and checked %0d block bytes,",
             strings_sent, bytes_checked);
    $display("with sender/receiver idling in both orders and a no-idle stretch; %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/fcb_pkg.sv
rtl/fcb_ifs.sv
rtl/fcb_front.sv
rtl/fcb_queue.sv
rtl/fcb_back.sv
rtl/fcb_filename_parser.sv
rtl/fcb_checker.sv
sim/fcb_filename_parser_test.sv
